### rtl/core/rmsl_pkg.sv
// Package for the region map block: shared types, state encoding and codes.
// Used by every module under rtl/core; has no dependencies of its own.
package rmsl_pkg;

    localparam int ADDR_W = 48;
    localparam int LIB_W  = 16;
    localparam int STAT_W = 3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_IGNORED  = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_HIT      = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_MISS     = 3'd4;

    // Request kinds.
    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_STACK_LIB = 1'b0;
    localparam logic CFG_STACK_LEN = 1'b1;

    // One stored region.
    typedef struct packed {
        logic [ADDR_W-1:0] rbegin;
        logic [ADDR_W-1:0] rend;
        logic [ADDR_W-1:0] roff;
        logic [LIB_W-1:0]  rlib;
    } region_t;

    // Control of the shared adder.
    typedef struct packed {
        logic sub;
        logic inc;
    } alu_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP_END,
        ST_PREP_DEC,
        ST_PREP_INC,
        ST_CHK_RD,
        ST_CHK_EV,
        ST_SPL_RD,
        ST_SPL_EV,
        ST_RGT_A,
        ST_RGT_B,
        ST_RGT_FIND,
        ST_RGT_WR,
        ST_NEW_FIND,
        ST_NEW_WR,
        ST_LK_RD,
        ST_LK_EV,
        ST_LK_SUB,
        ST_LK_ADD,
        ST_DONE
    } state_t;

endpackage

### rtl/core/rmsl_mem.sv
// Region store: one write port, one registered read port.
// Depends on rmsl_pkg for the region entry type.
module rmsl_mem #(
    parameter int DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  rmsl_pkg::region_t       wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output rmsl_pkg::region_t       rdata
);

    rmsl_pkg::region_t mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/rmsl_alu.sv
// Shared 48-bit adder used for every address and offset computation.
// Depends on rmsl_pkg for widths and the control struct.
module rmsl_alu (
    input  rmsl_pkg::alu_ctl_t             ctl,
    input  logic [rmsl_pkg::ADDR_W-1:0]    a,
    input  logic [rmsl_pkg::ADDR_W-1:0]    b,
    output logic [rmsl_pkg::ADDR_W-1:0]    sum,
    output logic                           carry
);

    logic [rmsl_pkg::ADDR_W-1:0] b_op;
    logic                        cin;

    // Add, subtract, or add/subtract one when inc is set.
    always_comb
    begin
        if (ctl.inc)
        begin
            b_op = ctl.sub ? {rmsl_pkg::ADDR_W{1'b1}} : '0;
            cin  = ~ctl.sub;
        end
        else
        begin
            b_op = ctl.sub ? ~b : b;
            cin  = ctl.sub;
        end
        {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{rmsl_pkg::ADDR_W{1'b0}}, cin};
    end

endmodule

### rtl/core/region_map_split_and_lookup.sv
// Top level of the region map: sequencer, valid bits and result register.
// Depends on rmsl_pkg, rmsl_mem and rmsl_alu.
//
// Channel | Dir | Contents
// s_*     | in  | request: tdata = address, length, file_offset, lib_id; tuser = action, is_anon
// m_*     | out | result: tdata = found_lib_id, translated_offset, regions_in_use; tuser = status
// cfg_*   | in  | register write: index 0 stack_lib_id, index 1 stack_length
//
// An insert runs the setup states (end, decrement, increment), an overlap scan of the table that
// stops early on a drop and ends in the result on a full map, a split pass that stops at each
// overlapped entry, adder steps and a free-slot search and write per right remainder, then a
// free-slot search, a write and the result. A lookup scans the table, then on a hit subtracts the
// begin and adds the offset. Scans go through the single read port; reset clears the valid bits.
// A finished result waits in the output register; the next request is taken meanwhile.
module region_map_split_and_lookup #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // address[47:0], length[95:48], file_offset[143:96], lib_id[159:144]
    input  logic [159:0]                           s_tdata,
    // action[0], is_anon[1]
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // found_lib_id[15:0], translated_offset[63:16], regions_in_use from bit 64, zero pad
    output logic [((64+$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]                             m_tuser,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [47:0]                            cfg_data
);

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W = ((64 + CW + 7) / 8) * 8;
    localparam logic [CW+2:0] DEPTH_W = (CW+3)'(TABLE_DEPTH);
    localparam logic [IW:0]   LAST_IDX = (IW+1)'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_FIDX = IW'(TABLE_DEPTH - 1);
    localparam logic [47:0]   ADDR_MAX = {48{1'b1}};

    rmsl_pkg::state_t state_reg, state_next;

    logic [IW:0]            idx_reg;
    logic [IW-1:0]          fidx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] hit_reg;
    logic [CW-1:0]          count_reg;
    logic [CW:0]            adds_reg;
    logic [CW:0]            subs_reg;

    logic [15:0] stack_lib_reg;
    logic [47:0] stack_len_reg;

    logic        act_reg;
    logic        anon_reg;
    logic [47:0] addr_reg;
    logic [47:0] len_reg;
    logic [47:0] off_reg;
    logic [15:0] lib_reg;
    logic [47:0] end_reg;
    logic [47:0] addr_m1_reg;
    logic [47:0] end_p1_reg;
    logic [15:0] eff_lib_reg;
    logic        eff_anon_reg;

    logic [47:0] tmp_reg;
    logic [47:0] ob_reg;
    logic [47:0] oo_reg;
    logic [47:0] rgt_end_reg;
    logic [15:0] rgt_lib_reg;

    logic              best_found_reg;
    rmsl_pkg::region_t best_reg;
    logic [2:0]        res_status_reg;

    logic        m_valid_reg;
    logic [2:0]  out_status_reg;
    logic [15:0] out_lib_reg;
    logic [47:0] out_off_reg;
    logic [CW-1:0] out_cnt_reg;

    // Memory and adder hookup.
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    rmsl_pkg::region_t mem_wdata;
    logic [IW-1:0]     mem_raddr;
    rmsl_pkg::region_t mem_rdata;
    rmsl_pkg::alu_ctl_t alu_ctl;
    logic [47:0]       alu_a;
    logic [47:0]       alu_b;
    logic [47:0]       alu_sum;
    logic              alu_carry;

    rmsl_mem #(
        .DEPTH(TABLE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rmsl_alu u_alu (
        .ctl   (alu_ctl),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Per-entry evaluation of the entry just read.
    logic cur_valid;
    logic cur_overlap;
    logic cur_hit;
    logic cur_drop;
    logic cur_left;
    logic cur_right;
    logic cur_best;
    logic in_accept;
    logic out_free;
    logic cap_over;
    logic [CW+2:0] cap_need;
    logic [CW+2:0] cap_have;

    always_comb
    begin
        cur_valid   = valid_reg[idx_reg[IW-1:0]];
        cur_overlap = (addr_reg > mem_rdata.rbegin) ? (mem_rdata.rend >= addr_reg)
                                                     : (end_reg >= mem_rdata.rbegin);
        cur_hit     = cur_valid && cur_overlap;
        cur_drop    = (eff_anon_reg && (addr_reg == off_reg) && (end_reg == mem_rdata.rend))
                   || ((end_reg <= mem_rdata.rend) && (eff_lib_reg == mem_rdata.rlib));
        cur_left    = mem_rdata.rbegin < addr_reg;
        cur_right   = mem_rdata.rend > end_reg;
        cur_best    = cur_valid && (mem_rdata.rbegin <= addr_reg)
                   && (!best_found_reg || (mem_rdata.rbegin > best_reg.rbegin));
        cap_need    = (CW+3)'(count_reg) + (CW+3)'(1) + (CW+3)'(adds_reg);
        cap_have    = DEPTH_W + (CW+3)'(subs_reg);
        cap_over    = cap_need > cap_have;
        in_accept   = s_tvalid && s_tready;
        out_free    = !m_valid_reg || m_tready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmsl_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_tuser[0] == rmsl_pkg::ACTION_LOOKUP) ? rmsl_pkg::ST_LK_RD
                                                                         : rmsl_pkg::ST_PREP_END;
                end
            end
            rmsl_pkg::ST_PREP_END: state_next = rmsl_pkg::ST_PREP_DEC;
            rmsl_pkg::ST_PREP_DEC: state_next = rmsl_pkg::ST_PREP_INC;
            rmsl_pkg::ST_PREP_INC: state_next = rmsl_pkg::ST_CHK_RD;
            rmsl_pkg::ST_CHK_RD:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = cap_over ? rmsl_pkg::ST_DONE : rmsl_pkg::ST_SPL_RD;
                end
                else
                begin
                    state_next = rmsl_pkg::ST_CHK_EV;
                end
            end
            rmsl_pkg::ST_CHK_EV:
            begin
                state_next = (cur_hit && cur_drop) ? rmsl_pkg::ST_DONE : rmsl_pkg::ST_CHK_RD;
            end
            rmsl_pkg::ST_SPL_RD:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = rmsl_pkg::ST_NEW_FIND;
                end
                else if (hit_reg[idx_reg[IW-1:0]])
                begin
                    state_next = rmsl_pkg::ST_SPL_EV;
                end
            end
            rmsl_pkg::ST_SPL_EV:
            begin
                state_next = cur_right ? rmsl_pkg::ST_RGT_A : rmsl_pkg::ST_SPL_RD;
            end
            rmsl_pkg::ST_RGT_A: state_next = rmsl_pkg::ST_RGT_B;
            rmsl_pkg::ST_RGT_B: state_next = rmsl_pkg::ST_RGT_FIND;
            rmsl_pkg::ST_RGT_FIND:
            begin
                if (!valid_reg[fidx_reg])
                begin
                    state_next = rmsl_pkg::ST_RGT_WR;
                end
            end
            rmsl_pkg::ST_RGT_WR: state_next = rmsl_pkg::ST_SPL_RD;
            rmsl_pkg::ST_NEW_FIND:
            begin
                if (!valid_reg[fidx_reg])
                begin
                    state_next = rmsl_pkg::ST_NEW_WR;
                end
            end
            rmsl_pkg::ST_NEW_WR: state_next = rmsl_pkg::ST_DONE;
            rmsl_pkg::ST_LK_RD:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    if (!best_found_reg || (addr_reg > best_reg.rend))
                    begin
                        state_next = rmsl_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = rmsl_pkg::ST_LK_SUB;
                    end
                end
                else
                begin
                    state_next = rmsl_pkg::ST_LK_EV;
                end
            end
            rmsl_pkg::ST_LK_EV:  state_next = rmsl_pkg::ST_LK_RD;
            rmsl_pkg::ST_LK_SUB: state_next = rmsl_pkg::ST_LK_ADD;
            rmsl_pkg::ST_LK_ADD: state_next = rmsl_pkg::ST_DONE;
            rmsl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rmsl_pkg::ST_IDLE;
                end
            end
            default: state_next = rmsl_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory port, adder operands, ready.
    always_comb
    begin
        s_tready    = (state_reg == rmsl_pkg::ST_IDLE);
        mem_raddr   = idx_reg[IW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = fidx_reg;
        mem_wdata   = '{rbegin: end_p1_reg, rend: rgt_end_reg, roff: tmp_reg,
                        rlib: rgt_lib_reg};
        alu_ctl     = '{sub: 1'b0, inc: 1'b0};
        alu_a       = addr_reg;
        alu_b       = len_reg;
        unique case (state_reg)
            rmsl_pkg::ST_PREP_DEC:
            begin
                alu_ctl = '{sub: 1'b1, inc: 1'b1};
            end
            rmsl_pkg::ST_PREP_INC:
            begin
                alu_ctl = '{sub: 1'b0, inc: 1'b1};
                alu_a   = end_reg;
            end
            rmsl_pkg::ST_SPL_EV:
            begin
                mem_we    = cur_left;
                mem_waddr = idx_reg[IW-1:0];
                mem_wdata = '{rbegin: mem_rdata.rbegin, rend: addr_m1_reg,
                              roff: mem_rdata.roff, rlib: mem_rdata.rlib};
            end
            rmsl_pkg::ST_RGT_A:
            begin
                alu_ctl = '{sub: 1'b1, inc: 1'b0};
                alu_a   = end_p1_reg;
                alu_b   = ob_reg;
            end
            rmsl_pkg::ST_RGT_B:
            begin
                alu_a = tmp_reg;
                alu_b = oo_reg;
            end
            rmsl_pkg::ST_RGT_WR:
            begin
                mem_we = 1'b1;
            end
            rmsl_pkg::ST_NEW_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{rbegin: addr_reg, rend: end_reg, roff: off_reg,
                              rlib: eff_lib_reg};
            end
            rmsl_pkg::ST_LK_SUB:
            begin
                alu_ctl = '{sub: 1'b1, inc: 1'b0};
                alu_b   = best_reg.rbegin;
            end
            rmsl_pkg::ST_LK_ADD:
            begin
                alu_a = tmp_reg;
                alu_b = best_reg.roff;
            end
            default:
            begin
                alu_ctl = '{sub: 1'b0, inc: 1'b0};
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rmsl_pkg::ST_IDLE;
            idx_reg        <= '0;
            fidx_reg       <= '0;
            valid_reg      <= '0;
            hit_reg        <= '0;
            count_reg      <= '0;
            adds_reg       <= '0;
            subs_reg       <= '0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            stack_lib_reg  <= '0;
            stack_len_reg  <= 48'd8392704;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_we)
            begin
                if (cfg_index == rmsl_pkg::CFG_STACK_LIB)
                begin
                    stack_lib_reg <= cfg_data[15:0];
                end
                else
                begin
                    stack_len_reg <= cfg_data;
                end
            end

            // Result register drains on the output handshake.
            if (state_reg == rmsl_pkg::ST_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                rmsl_pkg::ST_IDLE:
                begin
                    idx_reg        <= '0;
                    best_found_reg <= 1'b0;
                end
                rmsl_pkg::ST_PREP_INC:
                begin
                    idx_reg  <= '0;
                    hit_reg  <= '0;
                    adds_reg <= '0;
                    subs_reg <= '0;
                end
                rmsl_pkg::ST_CHK_RD:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg <= '0;
                    end
                end
                rmsl_pkg::ST_CHK_EV:
                begin
                    if (cur_hit)
                    begin
                        hit_reg[idx_reg[IW-1:0]] <= 1'b1;
                        subs_reg <= subs_reg + (CW+1)'(1);
                        adds_reg <= adds_reg + (CW+1)'(cur_left) + (CW+1)'(cur_right);
                    end
                    idx_reg <= idx_reg + (IW+1)'(1);
                end
                rmsl_pkg::ST_SPL_RD:
                begin
                    if (idx_reg != LAST_IDX && !hit_reg[idx_reg[IW-1:0]])
                    begin
                        idx_reg <= idx_reg + (IW+1)'(1);
                    end
                end
                rmsl_pkg::ST_SPL_EV:
                begin
                    hit_reg[idx_reg[IW-1:0]] <= 1'b0;
                    if (!cur_left)
                    begin
                        valid_reg[idx_reg[IW-1:0]] <= 1'b0;
                        count_reg <= count_reg - CW'(1);
                    end
                    if (!cur_right)
                    begin
                        idx_reg <= idx_reg + (IW+1)'(1);
                    end
                end
                rmsl_pkg::ST_RGT_FIND, rmsl_pkg::ST_NEW_FIND:
                begin
                    // The free-slot pointer wraps at the last table entry.
                    if (valid_reg[fidx_reg])
                    begin
                        fidx_reg <= (fidx_reg == LAST_FIDX) ? '0 : fidx_reg + IW'(1);
                    end
                end
                rmsl_pkg::ST_RGT_WR:
                begin
                    valid_reg[fidx_reg] <= 1'b1;
                    count_reg <= count_reg + CW'(1);
                    idx_reg   <= idx_reg + (IW+1)'(1);
                end
                rmsl_pkg::ST_NEW_WR:
                begin
                    valid_reg[fidx_reg] <= 1'b1;
                    count_reg <= count_reg + CW'(1);
                end
                rmsl_pkg::ST_LK_EV:
                begin
                    if (cur_best)
                    begin
                        best_found_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + (IW+1)'(1);
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Payload registers of the request in flight and the result.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= s_tuser[0];
            anon_reg <= s_tuser[1];
            addr_reg <= s_tdata[47:0];
            len_reg  <= s_tdata[95:48];
            off_reg  <= s_tdata[143:96];
            lib_reg  <= s_tdata[159:144];
        end

        unique case (state_reg)
            rmsl_pkg::ST_PREP_END:
            begin
                end_reg <= alu_carry ? ADDR_MAX : alu_sum;
                if (len_reg == stack_len_reg)
                begin
                    eff_lib_reg  <= stack_lib_reg;
                    eff_anon_reg <= 1'b0;
                end
                else
                begin
                    eff_lib_reg  <= lib_reg;
                    eff_anon_reg <= anon_reg;
                end
            end
            rmsl_pkg::ST_PREP_DEC: addr_m1_reg <= alu_sum;
            rmsl_pkg::ST_PREP_INC: end_p1_reg  <= alu_sum;
            rmsl_pkg::ST_CHK_RD:
            begin
                res_status_reg <= rmsl_pkg::STATUS_FULL;
            end
            rmsl_pkg::ST_CHK_EV:
            begin
                res_status_reg <= rmsl_pkg::STATUS_IGNORED;
            end
            rmsl_pkg::ST_SPL_EV:
            begin
                ob_reg      <= mem_rdata.rbegin;
                oo_reg      <= mem_rdata.roff;
                rgt_end_reg <= mem_rdata.rend;
                rgt_lib_reg <= mem_rdata.rlib;
            end
            rmsl_pkg::ST_RGT_A: tmp_reg <= alu_sum;
            rmsl_pkg::ST_RGT_B: tmp_reg <= alu_sum;
            rmsl_pkg::ST_NEW_WR:
            begin
                res_status_reg <= rmsl_pkg::STATUS_INSERTED;
            end
            rmsl_pkg::ST_LK_RD:
            begin
                res_status_reg <= rmsl_pkg::STATUS_MISS;
            end
            rmsl_pkg::ST_LK_EV:
            begin
                if (cur_best)
                begin
                    best_reg <= mem_rdata;
                end
            end
            rmsl_pkg::ST_LK_SUB: tmp_reg <= alu_sum;
            rmsl_pkg::ST_LK_ADD:
            begin
                tmp_reg        <= alu_sum;
                res_status_reg <= rmsl_pkg::STATUS_HIT;
            end
            rmsl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_cnt_reg    <= count_reg;
                    if (res_status_reg == rmsl_pkg::STATUS_HIT && act_reg)
                    begin
                        out_lib_reg <= best_reg.rlib;
                        out_off_reg <= tmp_reg;
                    end
                    else
                    begin
                        out_lib_reg <= '0;
                        out_off_reg <= '0;
                    end
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    // Result port.
    always_comb
    begin
        m_tvalid = m_valid_reg;
        m_tuser  = out_status_reg;
        m_tdata  = OUT_W'({out_cnt_reg, out_off_reg, out_lib_reg});
    end

endmodule

### rtl/core/rmsl_checker.sv
// Port-level checks for region_map_split_and_lookup and the bind that attaches them.
// Depends on rmsl_pkg for the status codes.
module rmsl_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((64+$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    input logic [2:0]                             m_tuser
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Status is always a defined code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= rmsl_pkg::STATUS_MISS)
        else $error("undefined status code");

    // Library id and offset are zero unless a lookup hit.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != rmsl_pkg::STATUS_HIT |-> m_tdata[63:0] == 64'd0)
        else $error("nonzero payload on a result that is not a hit");

    // Region count never exceeds the table depth.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[64 +: CW] <= CW'(TABLE_DEPTH))
        else $error("region count above table depth");

    // A request leaves the idle state, so ready drops after each one.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after a request");

endmodule

bind region_map_split_and_lookup rmsl_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_rmsl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/tb_top.sv
// Self-checking testbench for region_map_split_and_lookup: directed and random
// inserts and lookups, checked against a cycle-free region map predictor.
// Depends on rmsl_pkg and the region_map_split_and_lookup RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 800;
    localparam longint CYCLE_LIMIT = 6000000;

    // Expected contents of one result.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] lib;
        logic [47:0] offset;
        logic [6:0]  count;
    } map_result_t;

    // Region map predictor with a queue of expected results.
    class region_scoreboard;
        logic [47:0] rbeg[DEPTH];
        logic [47:0] rend[DEPTH];
        logic [47:0] roff[DEPTH];
        logic [15:0] rlib[DEPTH];
        bit          rval[DEPTH];
        logic [15:0] stack_lib;
        logic [47:0] stack_len;
        map_result_t pending[$];
        int          errors;

        function new();
            foreach (rval[i]) rval[i] = 0;
            stack_lib = 16'd0;
            stack_len = 48'd8392704;
            errors = 0;
        endfunction

        function int used_count();
            int n;
            n = 0;
            foreach (rval[i]) if (rval[i]) n++;
            return n;
        endfunction

        function int free_slot();
            for (int i = 0; i < DEPTH; i++) if (!rval[i]) return i;
            return -1;
        endfunction

        function bit overlap(logic [47:0] b1, logic [47:0] e1,
                             logic [47:0] b2, logic [47:0] e2);
            if (b1 > b2) return e2 >= b1;
            return e1 >= b2;
        endfunction

        function void store(int i, logic [47:0] b, logic [47:0] e,
                            logic [47:0] o, logic [15:0] l);
            rbeg[i] = b; rend[i] = e; roff[i] = o; rlib[i] = l; rval[i] = 1;
        endfunction

        // Insert with drop and capacity checks first, then split of every overlapped region.
        function logic [2:0] insert_map(logic [47:0] addr, logic [47:0] len,
                                        logic [47:0] off, logic [15:0] lib, bit anon);
            bit hit[DEPTH];
            logic [48:0] sum;
            logic [47:0] fin, ob, oe, oo;
            logic [15:0] elib, ol;
            bit eanon;
            int grow, slot;
            sum = {1'b0, addr} + {1'b0, len};
            fin = sum[48] ? MAX48 : sum[47:0];
            if (len == stack_len)
            begin
                elib = stack_lib;
                eanon = 0;
            end
            else
            begin
                elib = lib;
                eanon = anon;
            end
            grow = 1;
            for (int i = 0; i < DEPTH; i++)
            begin
                hit[i] = rval[i] && overlap(addr, fin, rbeg[i], rend[i]);
                if (!hit[i]) continue;
                if (eanon && addr == off && fin == rend[i]) return rmsl_pkg::STATUS_IGNORED;
                if (fin <= rend[i] && elib == rlib[i]) return rmsl_pkg::STATUS_IGNORED;
                grow--;
                if (rbeg[i] < addr) grow++;
                if (rend[i] > fin) grow++;
            end
            if (used_count() + grow > DEPTH) return rmsl_pkg::STATUS_FULL;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!hit[i]) continue;
                ob = rbeg[i]; oe = rend[i]; oo = roff[i]; ol = rlib[i];
                rval[i] = 0;
                if (ob < addr) store(i, ob, addr - 48'd1, oo, ol);
                if (oe > fin)
                begin
                    slot = free_slot();
                    if (slot >= 0) store(slot, fin + 48'd1, oe, oo + (fin + 48'd1 - ob), ol);
                end
            end
            slot = free_slot();
            if (slot >= 0) store(slot, addr, fin, off, elib);
            return rmsl_pkg::STATUS_INSERTED;
        endfunction

        // Note an accepted request and queue its expected result.
        function void note_request(bit action, logic [47:0] addr, logic [47:0] len,
                                   logic [47:0] off, logic [15:0] lib, bit anon);
            map_result_t r;
            int best;
            r = '0;
            if (action == rmsl_pkg::ACTION_INSERT)
            begin
                r.status = insert_map(addr, len, off, lib, anon);
            end
            else
            begin
                best = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (rval[i] && rbeg[i] <= addr && (best < 0 || rbeg[i] > rbeg[best]))
                        best = i;
                if (best < 0 || addr > rend[best])
                begin
                    r.status = rmsl_pkg::STATUS_MISS;
                end
                else
                begin
                    r.status = rmsl_pkg::STATUS_HIT;
                    r.lib = rlib[best];
                    r.offset = addr - rbeg[best] + roff[best];
                end
            end
            r.count = 7'(used_count());
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result with the oldest expectation.
        task check_result(map_result_t got);
            map_result_t exp_r;
            if (pending.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
                report($sformatf("status %0d, want %0d", got.status, exp_r.status));
            if (got.lib !== exp_r.lib)
                report($sformatf("found_lib_id %h, want %h", got.lib, exp_r.lib));
            if (got.offset !== exp_r.offset)
                report($sformatf("translated_offset %h, want %h", got.offset, exp_r.offset));
            if (got.count !== exp_r.count)
                report($sformatf("regions_in_use %0d, want %0d", got.count, exp_r.count));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we;
    logic         cfg_index;
    logic [47:0]  cfg_data;

    region_scoreboard sb;
    bit      idle_en;
    int      stall_left;
    longint  cycles;

    region_map_split_and_lookup #(.TABLE_DEPTH(DEPTH)) uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: check on handshake, then choose the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result({m_tuser, m_tdata[15:0], m_tdata[63:16], m_tdata[70:64]});
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left <= pick_gap();
            m_tready <= 1'b1;
        end
    end

    // Send one request and wait until it is taken.
    task send(bit action, logic [47:0] addr, logic [47:0] len, logic [47:0] off,
              logic [15:0] lib, bit anon);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {lib, off, len, addr};
        s_tuser <= {anon, action};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(action, addr, len, off, lib, anon);
    endtask

    task write_reg(logic idx, logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rmsl_pkg::CFG_STACK_LIB) sb.stack_lib = val[15:0];
        else sb.stack_len = val;
    endtask

    // Let the block drain before touching the registers.
    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function logic [47:0] rand48();
        return {$urandom, $urandom} & MAX48;
    endfunction

    // Index of a random valid region, or -1 when the map is empty.
    function int any_region();
        if (sb.used_count() == 0) return -1;
        forever
        begin
            int i;
            i = $urandom_range(0, DEPTH - 1);
            if (sb.rval[i]) return i;
        end
    endfunction

    // One random request, mostly clustered so that regions overlap.
    task random_item(logic [47:0] base);
        int kind, i;
        logic [47:0] a, l, o;
        logic [15:0] lib;
        bit anon;
        kind = $urandom_range(0, 99);
        a = base + $urandom_range(0, 'h3FFF);
        l = $urandom_range(0, 'h7FF);
        o = rand48();
        lib = $urandom_range(0, 7);
        anon = $urandom_range(0, 1);
        i = any_region();
        if (kind < 35)
        begin
            if (i >= 0 && $urandom_range(0, 1)) a = sb.rbeg[i] + $urandom_range(0, 'h100);
            send(rmsl_pkg::ACTION_LOOKUP, $urandom_range(0, 9) == 0 ? rand48() : a, rand48(),
                 rand48(), $urandom, $urandom_range(0, 1));
        end
        else if (kind < 45 && i >= 0)
        begin
            // Anonymous remap starting at its offset and ending with a region.
            a = sb.rbeg[i] + $urandom_range(0, 15);
            if (a > sb.rend[i]) a = sb.rbeg[i];
            send(rmsl_pkg::ACTION_INSERT, a, sb.rend[i] - a, a, lib, 1'b1);
        end
        else if (kind < 55 && i >= 0)
        begin
            // Same library ending inside an existing region.
            a = sb.rbeg[i];
            send(rmsl_pkg::ACTION_INSERT, a, (sb.rend[i] - a) >> $urandom_range(0, 2), o,
                 sb.rlib[i], anon);
        end
        else if (kind < 62)
            send(rmsl_pkg::ACTION_INSERT, a, sb.stack_len, o, lib, anon);
        else if (kind < 65)
            // Wide insert that swallows most of the cluster.
            send(rmsl_pkg::ACTION_INSERT, base - $urandom_range(0, 'h40), 'h5000, o, lib, anon);
        else if (kind < 70)
            send(rmsl_pkg::ACTION_INSERT, rand48(), rand48(), o, $urandom, anon);
        else
            send(rmsl_pkg::ACTION_INSERT, a, l, o, lib, anon);
    endtask

    initial
    begin
        logic [47:0] base;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rmsl_pkg::CFG_STACK_LIB;
        cfg_data = '0;
        cycles = 0;
        stall_left = 0;
        idle_en = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset register values.
        send(rmsl_pkg::ACTION_LOOKUP, 48'h1000, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_INSERT, 48'h1000, 48'hFFF, 48'h20, 16'h1, 0);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h1800, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h2000, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h0FFF, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_INSERT, 48'h1400, 48'h100, 48'h7, 16'h2, 0);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h1600, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_INSERT, 48'h1100, 48'h10, 48'h9, 16'h1, 0);
        send(rmsl_pkg::ACTION_INSERT, 48'h1700, 48'h8FF, 48'h1700, 16'h5, 1);
        send(rmsl_pkg::ACTION_INSERT, 48'h1700, 48'h8FF, 48'h1700, 16'h5, 0);
        send(rmsl_pkg::ACTION_INSERT, 48'h3000, 48'd8392704, 48'h3000, 16'hFFFF, 1);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h3005, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_INSERT, MAX48 - 48'h10, MAX48, MAX48, 16'hFFFF, 0);
        send(rmsl_pkg::ACTION_LOOKUP, MAX48, MAX48, MAX48, 16'hFFFF, 1);
        send(rmsl_pkg::ACTION_INSERT, 48'h0, 48'h0, MAX48, 16'hAAAA, 0);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h0, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_INSERT, 48'h0F00, 48'h400, MAX48 - 48'h80, 16'h5555, 1);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h1300, 0, 0, 0, 0);
        send(rmsl_pkg::ACTION_INSERT, 48'h0, MAX48, 48'h0, 16'h3, 0);
        send(rmsl_pkg::ACTION_LOOKUP, 48'h8000_0000_0000, 0, 0, 0, 0);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(rmsl_pkg::CFG_STACK_LIB, 48'h0);
                    write_reg(rmsl_pkg::CFG_STACK_LEN, 48'd8392704);
                end
                1:
                begin
                    write_reg(rmsl_pkg::CFG_STACK_LIB, 48'hFFFF);
                    write_reg(rmsl_pkg::CFG_STACK_LEN, 48'h0);
                end
                2:
                begin
                    write_reg(rmsl_pkg::CFG_STACK_LIB, 48'h1234);
                    write_reg(rmsl_pkg::CFG_STACK_LEN, MAX48);
                end
                3:
                begin
                    write_reg(rmsl_pkg::CFG_STACK_LIB, $urandom);
                    write_reg(rmsl_pkg::CFG_STACK_LEN, 48'h40);
                end
                default:
                begin
                    write_reg(rmsl_pkg::CFG_STACK_LIB, $urandom_range(0, 7));
                    write_reg(rmsl_pkg::CFG_STACK_LEN, 48'h200);
                end
            endcase
            idle_en = (ph != 2);
            base = (ph == 4) ? (MAX48 - 48'h3000) : rand48() & 48'hFFFF_FFFF_0000;
            // Start from a clean cluster so the map fills and splits again.
            send(rmsl_pkg::ACTION_INSERT, base - 48'h100, 48'h6000, 0, 16'h7, 0);
            repeat (325) random_item(base);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
